>>> sv/drum_hit_peak_detector_macros.svh
// assertion macros shared by the drum hit peak detector checker
`ifndef DRUM_HIT_PEAK_DETECTOR_MACROS_SVH
`define DRUM_HIT_PEAK_DETECTOR_MACROS_SVH

// property checked on aclk, ignored while reset is asserted
`define DHPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked on aclk, also during reset
`define DHPD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> sv/dhpd_pkg.sv
// shared types and constants of the drum hit peak detector
`timescale 1ns / 1ps

package dhpd_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_TRIGGER_LEVEL = 2'd0;
    localparam logic [1:0] REG_RISE_MARGIN   = 2'd1;
    localparam logic [1:0] REG_REARM_PEAKS   = 2'd2;
    localparam logic [1:0] REG_FALL_COUNT    = 2'd3;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;
    localparam int TRIGGER_BITS   = 24;
    localparam int MARGIN_BITS    = 23;
    localparam int REARM_BITS     = 4;
    localparam int FALL_BITS      = 4;

    // reset values: margin is 0.12 V of a 5 V full scale, in counts
    localparam logic signed [TRIGGER_BITS-1:0] TRIGGER_RESET = '0;
    localparam logic [MARGIN_BITS-1:0]         MARGIN_RESET  = 23'd201327;
    localparam logic [REARM_BITS-1:0]          REARM_RESET   = 4'd2;
    localparam logic [FALL_BITS-1:0]           FALL_RESET    = 4'd2;

    typedef struct packed {
        logic signed [TRIGGER_BITS-1:0] trigger_level;
        logic [MARGIN_BITS-1:0]         rise_margin;
        logic [REARM_BITS-1:0]          rearm_peaks;
        logic [FALL_BITS-1:0]           fall_count;
    } dhpd_cfg_t;

    // hit_found in bit 0, follow_peak in bit 1
    typedef struct packed {
        logic follow_peak;
        logic hit_found;
    } dhpd_flags_t;

endpackage

>>> sv/dhpd_cfg.sv
// configuration register file of the drum hit peak detector
`timescale 1ns / 1ps

module dhpd_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [dhpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dhpd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output dhpd_pkg::dhpd_cfg_t                  cfg
);
    import dhpd_pkg::*;

    dhpd_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_level <= TRIGGER_RESET;
            cfg_reg.rise_margin   <= MARGIN_RESET;
            cfg_reg.rearm_peaks   <= REARM_RESET;
            cfg_reg.fall_count    <= FALL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TRIGGER_LEVEL: cfg_reg.trigger_level <= cfg_data[TRIGGER_BITS-1:0];
                REG_RISE_MARGIN:   cfg_reg.rise_margin   <= cfg_data[MARGIN_BITS-1:0];
                REG_REARM_PEAKS:   cfg_reg.rearm_peaks   <= cfg_data[REARM_BITS-1:0];
                REG_FALL_COUNT:    cfg_reg.fall_count    <= cfg_data[FALL_BITS-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/dhpd_core.sv
// peak search state machine: one sample per step, peak result when a search ends
`timescale 1ns / 1ps

module dhpd_core #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dhpd_pkg::dhpd_cfg_t           cfg,
    input  logic                          step,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          res_valid,
    output dhpd_pkg::dhpd_flags_t         res_flags,
    output logic signed [SAMPLE_BITS-1:0] res_level,
    output logic [COUNT_BITS-1:0]         res_index
);
    import dhpd_pkg::*;

    localparam int WIDE_BITS = (SAMPLE_BITS > TRIGGER_BITS) ? SAMPLE_BITS : TRIGGER_BITS;
    localparam int CMP_BITS  = WIDE_BITS + 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_SEARCH,
        PH_WAIT
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [COUNT_BITS-1:0]         index_reg, index_next;
    logic [FALL_BITS-1:0]          fall_reg, fall_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0] last_reg, last_next;
    logic [REARM_BITS-1:0]         rearm_reg, rearm_next;

    logic signed [CMP_BITS-1:0] sample_ext, trigger_ext, max_ext, bar_ext;
    logic [FALL_BITS-1:0]       fall_limit, fall_inc;
    logic [REARM_BITS-1:0]      rearm_dec;
    logic                       finish, follow, hit;

    assign sample_ext  = CMP_BITS'(sample);
    assign trigger_ext = CMP_BITS'($signed(cfg.trigger_level));
    assign max_ext     = CMP_BITS'(max_reg);
    // previous peak plus margin, exact in the widened range
    assign bar_ext     = CMP_BITS'(last_reg) + $signed(CMP_BITS'(cfg.rise_margin));

    assign fall_limit = (cfg.fall_count == '0) ? FALL_BITS'(1) : cfg.fall_count;
    assign fall_inc   = fall_reg + FALL_BITS'(1);
    assign follow     = (rearm_reg != '0);
    assign rearm_dec  = follow ? (rearm_reg - REARM_BITS'(1)) : rearm_reg;
    assign hit        = (max_ext > bar_ext) && (rearm_dec == '0);

    always_comb begin
        phase_next = phase_reg;
        max_next   = max_reg;
        index_next = index_reg;
        fall_next  = fall_reg;
        count_next = count_reg + COUNT_BITS'(1);
        last_next  = last_reg;
        rearm_next = rearm_reg;
        finish     = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (sample_ext > trigger_ext) begin
                    phase_next = PH_FIRST;
                end
            end
            PH_FIRST: begin
                max_next   = sample;
                index_next = count_next;
                fall_next  = '0;
                phase_next = PH_SEARCH;
            end
            PH_SEARCH: begin
                if (sample > max_reg) begin
                    max_next   = sample;
                    index_next = count_next;
                    fall_next  = '0;
                end else if (fall_inc < fall_limit) begin
                    fall_next = fall_inc;
                end else begin
                    finish     = 1'b1;
                    phase_next = PH_WAIT;
                    fall_next  = '0;
                    rearm_next = hit ? cfg.rearm_peaks : rearm_dec;
                    last_next  = max_reg;
                end
            end
            PH_WAIT: begin
                if (sample <= 0) begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            max_reg   <= '0;
            index_reg <= '0;
            fall_reg  <= '0;
            count_reg <= '0;
            last_reg  <= '0;
            rearm_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            max_reg   <= max_next;
            index_reg <= index_next;
            fall_reg  <= fall_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            rearm_reg <= rearm_next;
        end
    end

    assign res_valid             = step && finish;
    assign res_flags.hit_found   = hit;
    assign res_flags.follow_peak = follow;
    assign res_level             = max_reg;
    assign res_index             = index_reg;

endmodule

>>> sv/drum_hit_peak_detector.sv
// top level of the drum hit peak detector: config registers, input stage, peak search core, result register
`timescale 1ns / 1ps

// drum hit peak detector
// takes one signed converter sample per item and reports one result item per
// finished peak. a sample above trigger_level arms a search, the next sample
// starts the running maximum and the search ends after fall_count non-rising
// samples in a row (0 acts as 1). each finished peak is reported: follow_peak
// is set while the re-arm counter was above zero, hit_found when the peak beats
// the previous peak by more than rise_margin with the decremented counter at zero,
// which reloads it from rearm_peaks. after a peak the block waits for a sample at
// or below zero. peak_index is a free running sample count, first sample = 1.
// throughput: one item per clock, sustained while results are taken. the
// sample that ends a peak is loaded into the input register; stepping it
// advances the state and loads the result register, and it is stepped only
// once the result register is free. the input side stalls while a result
// waits untaken and the input register is full, whether or not the held
// sample ends another peak.
// configuration: write cfg_data to register cfg_index with cfg_wr_en, only
// while no item is in flight (0 trigger_level, 1 rise_margin, 2 rearm_peaks,
// 3 fall_count).
module drum_hit_peak_detector #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [dhpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dhpd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // sample items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: sample_code
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // peak result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: peak_level, peak_index
    output logic [((SAMPLE_BITS+COUNT_BITS+7)/8)*8-1:0] m_axis_tdata,
    // tuser: hit_found, follow_peak
    output logic [1:0]                          m_axis_tuser
);
    import dhpd_pkg::*;

    localparam int OUT_TDATA_BITS = ((SAMPLE_BITS + COUNT_BITS + 7) / 8) * 8;

    dhpd_cfg_t cfg;

    // input register
    logic                          in_valid_reg, in_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    // result register
    logic                          out_valid_reg, out_valid_next;
    dhpd_flags_t                   flags_reg;
    logic signed [SAMPLE_BITS-1:0] level_reg;
    logic [COUNT_BITS-1:0]         index_reg;

    // core result of the sample being stepped
    logic                          step;
    logic                          res_valid;
    dhpd_flags_t                   res_flags;
    logic signed [SAMPLE_BITS-1:0] res_level;
    logic [COUNT_BITS-1:0]         res_index;
    logic                          out_free;
    logic                          s_accept;

    dhpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dhpd_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step      (step),
        .sample    (sample_reg),
        .res_valid (res_valid),
        .res_flags (res_flags),
        .res_level (res_level),
        .res_index (res_index)
    );

    // the result register is free when empty or being drained this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    // a held sample is stepped once a result, if any, has room to land
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || step;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !step);
    assign out_valid_next = res_valid || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (res_valid) begin
            flags_reg <= res_flags;
            level_reg <= res_level;
            index_reg <= res_index;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_BITS'({index_reg, level_reg});
    assign m_axis_tuser  = flags_reg;

endmodule

>>> sv/dhpd_checker.sv
// port level checks of the drum hit peak detector, bound to the top level
`timescale 1ns / 1ps
`include "drum_hit_peak_detector_macros.svh"

module dhpd_checker #(
    parameter int M_TDATA_BITS = 56
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [M_TDATA_BITS-1:0] m_axis_tdata,
    input logic [1:0]              m_axis_tuser
);

    // no result survives a reset
    `DHPD_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_axis_tvalid, "result valid after reset")

    // with no result pending the input side never stalls
    `DHPD_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

    // a taken result frees the path for the next sample
    `DHPD_ASSERT(a_ready_on_drain, (m_axis_tvalid && m_axis_tready) |-> s_axis_tready, "input stalled while result drains")

    // a waiting result stays and holds its payload
    `DHPD_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

endmodule

bind drum_hit_peak_detector dhpd_checker #(
    .M_TDATA_BITS (((SAMPLE_BITS + COUNT_BITS + 7) / 8) * 8)
) u_dhpd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
